[sv/grouped_record_stream_checker_assert.svh]
// Assertion macros for the grouped record stream checker.
// Included by the top level; no other dependencies.
`ifndef GROUPED_RECORD_STREAM_CHECKER_ASSERT_SVH
`define GROUPED_RECORD_STREAM_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS
`define GRSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define GRSC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define GRSC_ASSERT(lbl, clk, rstn, prop, msg)
`define GRSC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

[sv/grsc_pkg.sv]
// Shared types and constants of the grouped record stream checker.
// No dependencies; used by the interfaces, the FSM, the datapath and the top level.
package grsc_pkg;

  localparam int EVENT_W = 31;
  localparam int AREA_W  = 32;
  localparam int BIN_W   = 16;
  localparam int PROB_W  = 25;
  localparam int SUM_W   = 32;
  localparam int ORDER_W = 2;
  localparam int CFG_A_W = 1;

  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [AREA_W-1:0]  area_t;
  typedef logic [BIN_W-1:0]   bin_t;
  typedef logic [PROB_W-1:0]  prob_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [ORDER_W-1:0] order_t;
  typedef logic [CFG_A_W-1:0] cfg_addr_t;

  localparam sum_t SUM_LOW_RESET  = 32'd16776378;
  localparam sum_t SUM_HIGH_RESET = 32'd16778055;
  localparam sum_t SUM_MAX        = '1;

  localparam cfg_addr_t REG_SUM_LOW  = 1'd0;
  localparam cfg_addr_t REG_SUM_HIGH = 1'd1;

  localparam order_t ORD_NONE  = 2'd0;
  localparam order_t ORD_EVENT = 2'd1;
  localparam order_t ORD_AREA  = 2'd2;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_END    = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

[sv/grsc_ifs.sv]
// Channel interfaces: record input, result output, register write port.
// Depends on grsc_pkg.
interface grsc_in_if;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  grsc_pkg::event_t      evt_id;
  grsc_pkg::area_t       area_id;
  grsc_pkg::bin_t        bin_id;
  grsc_pkg::prob_t       prob;
  modport source (output valid, mode, evt_id, area_id, bin_id, prob, input ready);
  modport sink   (input valid, mode, evt_id, area_id, bin_id, prob, output ready);
endinterface

interface grsc_out_if;
  logic                  valid;
  logic                  ready;
  logic                  group_closed;
  logic                  sum_bad;
  grsc_pkg::order_t      order_fault;
  logic                  duplicate_bin;
  logic                  bin_overflow;
  grsc_pkg::sum_t        closed_sum;
  grsc_pkg::bin_t        largest_bin;
  modport source (output valid, group_closed, sum_bad, order_fault, duplicate_bin,
                  bin_overflow, closed_sum, largest_bin, input ready);
  modport sink   (input valid, group_closed, sum_bad, order_fault, duplicate_bin,
                  bin_overflow, closed_sum, largest_bin, output ready);
endinterface

interface grsc_cfg_if;
  logic                  valid;
  logic                  ready;
  grsc_pkg::cfg_addr_t   addr;
  grsc_pkg::sum_t        data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[sv/grsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/grsc_ctrl.sv]
// Sequencing FSM: accept, bin list walk, commit into the output register.
// Depends on grsc_pkg.
module grsc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output grsc_pkg::cmd_t    cmd,
  input  grsc_pkg::status_t status
);
  import grsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/grsc_dp.sv]
// Datapath: item latch, group state, bin list walk, bounds/order checks,
// output register. Depends on grsc_pkg and grsc_ram.
module grsc_dp #(
  parameter int MAX_BINS_PER_GROUP = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  grsc_pkg::cmd_t      cmd,
  output grsc_pkg::status_t   status,
  // register writes
  input  logic                cfg_we,
  input  grsc_pkg::cfg_addr_t cfg_addr,
  input  grsc_pkg::sum_t      cfg_data,
  // item payload
  input  logic                in_mode,
  input  grsc_pkg::event_t    in_evt_id,
  input  grsc_pkg::area_t     in_area_id,
  input  grsc_pkg::bin_t      in_bin_id,
  input  grsc_pkg::prob_t     in_prob,
  // result
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_group_closed,
  output logic                out_sum_bad,
  output grsc_pkg::order_t    out_order_fault,
  output logic                out_duplicate_bin,
  output logic                out_bin_overflow,
  output grsc_pkg::sum_t      out_closed_sum,
  output grsc_pkg::bin_t      out_largest_bin
);
  import grsc_pkg::*;

  localparam int IW = $clog2(MAX_BINS_PER_GROUP);
  localparam int CW = $clog2(MAX_BINS_PER_GROUP + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_BINS_PER_GROUP);

  // latched item
  logic   mode_r;
  event_t ev_r;
  area_t  ar_r;
  bin_t   bin_r;
  prob_t  prob_r;

  sum_t   lo_r, lo_nxt, hi_r, hi_nxt;

  logic          have_r, have_nxt;
  event_t        last_ev_r, last_ev_nxt;
  area_t         last_ar_r, last_ar_nxt;
  sum_t          sum_r, sum_nxt;
  logic [CW-1:0] count_r, count_nxt;
  bin_t          top_r, top_nxt;

  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          hit_r, hit_nxt;

  logic   out_vld_r, out_vld_nxt;
  logic   o_closed_r, o_bad_r, o_dup_r, o_ovf_r;
  order_t o_order_r;
  sum_t   o_csum_r;
  bin_t   o_top_r;

  logic   o_closed, o_bad, o_dup, o_ovf;
  order_t o_order;
  sum_t   o_csum;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  bin_t          ram_rdata;

  logic          same_pair, need_scan, match, scan_more, sum_out;
  logic [SUM_W:0] sum_add;

  grsc_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_BINS_PER_GROUP)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (bin_r),
    .raddr (scan_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign same_pair = (ev_r == last_ev_r) && (ar_r == last_ar_r);
  assign need_scan = (mode_r == MODE_RECORD) && have_r && same_pair;
  assign match     = pend_r && (ram_rdata == bin_r);
  assign scan_more = scan_idx_r < count_r;
  assign sum_out   = (sum_r < lo_r) || (sum_r >= hi_r);
  assign sum_add   = {1'b0, sum_r} + {{(SUM_W + 1 - PROB_W){1'b0}}, prob_r};

  assign status.scan_done = !need_scan || hit_r || match || (!scan_more && !pend_r);
  assign status.out_free  = !out_vld_r || out_ready;

  // registers
  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SUM_LOW:  lo_nxt = cfg_data;
        REG_SUM_HIGH: hi_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // bin list walk: one read issued per cycle, compared in the next cycle
  always_comb begin
    scan_idx_nxt = scan_idx_r;
    pend_nxt     = pend_r;
    hit_nxt      = hit_r;
    if (cmd.accept) begin
      scan_idx_nxt = '0;
      pend_nxt     = 1'b0;
      hit_nxt      = 1'b0;
    end else if (cmd.scan && need_scan) begin
      hit_nxt = hit_r || match;
      if (scan_more && !(hit_r || match)) begin
        scan_idx_nxt = scan_idx_r + CW'(1);
        pend_nxt     = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end
  end

  // group update and result, applied on commit
  always_comb begin
    have_nxt    = have_r;
    last_ev_nxt = last_ev_r;
    last_ar_nxt = last_ar_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    top_nxt     = top_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    o_closed    = 1'b0;
    o_bad       = 1'b0;
    o_order     = ORD_NONE;
    o_dup       = 1'b0;
    o_ovf       = 1'b0;
    o_csum      = '0;

    if (mode_r == MODE_END) begin
      if (have_r) begin
        o_closed  = 1'b1;
        o_csum    = sum_r;
        o_bad     = sum_out;
        have_nxt  = 1'b0;
        sum_nxt   = '0;
        count_nxt = '0;
      end
    end else begin
      if (!have_r || !same_pair) begin
        if (have_r) begin
          o_closed = 1'b1;
          o_csum   = sum_r;
          o_bad    = sum_out;
          if (ev_r < last_ev_r) begin
            o_order = ORD_EVENT;
          end else if (ev_r == last_ev_r && ar_r < last_ar_r) begin
            o_order = ORD_AREA;
          end
        end
        have_nxt    = 1'b1;
        last_ev_nxt = ev_r;
        last_ar_nxt = ar_r;
        ram_we      = 1'b1;
        ram_waddr   = '0;
        count_nxt   = CW'(1);
        sum_nxt     = SUM_W'(prob_r);
      end else begin
        if (hit_r) begin
          o_dup = 1'b1;
        end else if (count_r < COUNT_MAX) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IW-1:0];
          count_nxt = count_r + CW'(1);
        end else begin
          o_ovf = 1'b1;
        end
        sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end
      if (bin_r > top_r) begin
        top_nxt = bin_r;
      end
    end

    if (!cmd.commit) begin
      have_nxt    = have_r;
      last_ev_nxt = last_ev_r;
      last_ar_nxt = last_ar_r;
      sum_nxt     = sum_r;
      count_nxt   = count_r;
      top_nxt     = top_r;
      ram_we      = 1'b0;
    end
  end

  assign out_vld_nxt = cmd.commit || (out_vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r       <= SUM_LOW_RESET;
      hi_r       <= SUM_HIGH_RESET;
      have_r     <= 1'b0;
      last_ev_r  <= '0;
      last_ar_r  <= '0;
      sum_r      <= '0;
      count_r    <= '0;
      top_r      <= '0;
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
      hit_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
      have_r     <= have_nxt;
      last_ev_r  <= last_ev_nxt;
      last_ar_r  <= last_ar_nxt;
      sum_r      <= sum_nxt;
      count_r    <= count_nxt;
      top_r      <= top_nxt;
      scan_idx_r <= scan_idx_nxt;
      pend_r     <= pend_nxt;
      hit_r      <= hit_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_mode;
      ev_r   <= in_evt_id;
      ar_r   <= in_area_id;
      bin_r  <= in_bin_id;
      prob_r <= in_prob;
    end
    if (cmd.commit) begin
      o_closed_r <= o_closed;
      o_bad_r    <= o_bad;
      o_order_r  <= o_order;
      o_dup_r    <= o_dup;
      o_ovf_r    <= o_ovf;
      o_csum_r   <= o_csum;
      o_top_r    <= top_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_group_closed  = o_closed_r;
  assign out_sum_bad       = o_bad_r;
  assign out_order_fault   = o_order_r;
  assign out_duplicate_bin = o_dup_r;
  assign out_bin_overflow  = o_ovf_r;
  assign out_closed_sum    = o_csum_r;
  assign out_largest_bin   = o_top_r;

endmodule

[sv/grouped_record_stream_checker.sv]
// Top level of the grouped record stream checker: FSM plus datapath.
// Depends on grsc_pkg, grsc_ifs, grsc_ctrl, grsc_dp and the assertion header.
//
// Checks a stream of (event, area, bin, probability) records grouped by
// event/area pair and returns one result per item. An item that opens or
// closes a group, or ends the stream, goes from accept to commit without
// a bin list walk; a record inside an open group walks the bin ids that
// the group already holds and stops early if the bin is found. The bin list
// sits in a RAM with one write and one read port that is read one entry per
// cycle. The result register lets the next item be taken while a result
// still waits on out_ch. The bin list needs no clearing after reset.
// Register writes (index 0 low bound, 1 high bound) are always ready.
`include "grouped_record_stream_checker_assert.svh"

module grouped_record_stream_checker #(
  parameter int MAX_BINS_PER_GROUP = 64
) (
  input logic       clk,
  input logic       rst_n,
  grsc_in_if.sink   in_ch,
  grsc_out_if.source out_ch,
  grsc_cfg_if.sink  cfg_ch
);
  import grsc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  grsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  grsc_dp #(
    .MAX_BINS_PER_GROUP (MAX_BINS_PER_GROUP)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_ch.valid),
    .cfg_addr          (cfg_ch.addr),
    .cfg_data          (cfg_ch.data),
    .in_mode           (in_ch.mode),
    .in_evt_id         (in_ch.evt_id),
    .in_area_id        (in_ch.area_id),
    .in_bin_id         (in_ch.bin_id),
    .in_prob           (in_ch.prob),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_group_closed  (out_ch.group_closed),
    .out_sum_bad       (out_ch.sum_bad),
    .out_order_fault   (out_ch.order_fault),
    .out_duplicate_bin (out_ch.duplicate_bin),
    .out_bin_overflow  (out_ch.bin_overflow),
    .out_closed_sum    (out_ch.closed_sum),
    .out_largest_bin   (out_ch.largest_bin)
  );

  // a result never overwrites one that has not been taken
  `GRSC_ASSERT(a_commit_free, clk, rst_n, cmd.commit |-> status.out_free, "commit when full")
  // while the input is open no item is in flight
  `GRSC_ASSERT_NEVER(a_idle_quiet, clk, rst_n, in_ready && (cmd.scan || cmd.commit), "busy")
  // every commit shows up as a valid result
  `GRSC_ASSERT(a_commit_out, clk, rst_n, cmd.commit |=> out_ch.valid, "result lost")
  // a result is either closing info or record info, never both
  `GRSC_ASSERT_NEVER(a_out_excl, clk, rst_n, out_ch.valid && out_ch.group_closed && (out_ch.duplicate_bin || out_ch.bin_overflow), "flags mixed")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for grouped_record_stream_checker: drives record streams and
// bound writes, predicts every result in a scoreboard and compares each field.
// Depends on grsc_pkg, grsc_ifs and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import grsc_pkg::*;

  localparam int          BIN_LIST_DEPTH  = 64;
  localparam int unsigned Q24_ONE         = 32'd1 << 24;
  localparam int unsigned PROB_MAX        = (32'd1 << 25) - 1;
  localparam int unsigned PROB_HEAVY_MIN  = PROB_MAX - (32'd1 << 20);
  localparam int          RANDOM_RECORDS  = 1600;
  localparam int          RANDOM_PHASES   = 6;
  localparam int          RX_HOLD_CYCLES  = 400;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int          CYCLE_LIMIT     = 1_000_000;

  typedef struct packed {
    logic   group_closed;
    logic   sum_bad;
    order_t order_fault;
    logic   duplicate_bin;
    logic   bin_overflow;
    sum_t   closed_sum;
    bin_t   largest_bin;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;

  grsc_in_if  in_ch();
  grsc_out_if out_ch();
  grsc_cfg_if cfg_ch();

  grouped_record_stream_checker #(
    .MAX_BINS_PER_GROUP(BIN_LIST_DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  sum_t     bound_lo = SUM_LOW_RESET;
  sum_t     bound_hi = SUM_HIGH_RESET;
  logic     grp_open = 1'b0;
  event_t   grp_event = '0;
  area_t    grp_area = '0;
  sum_t     grp_sum = '0;
  bin_t     grp_bins[$];
  bin_t     top_bin_seen = '0;
  verdict_t pending_verdicts[$];

  // stream generator state
  event_t gen_event = '0;
  area_t  gen_area = '0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_hold_req = 1'b0;

  int err_count = 0;
  int records_sent = 0;
  int items_sent = 0;
  int results_seen = 0;
  int closed_cnt = 0;
  int bad_cnt = 0;
  int order_cnt = 0;
  int dup_cnt = 0;
  int ovf_cnt = 0;
  int sat_cnt = 0;
  int cycle_count = 0;

  function automatic logic sum_out_of_bounds(input sum_t s);
    return (s < bound_lo) || (s >= bound_hi);
  endfunction

  function automatic verdict_t verdict_for_record(input logic mode, input event_t ev,
                                                  input area_t ar, input bin_t bin,
                                                  input prob_t p);
    verdict_t       v;
    logic           found;
    logic [SUM_W:0] acc;
    v = '0;
    found = 1'b0;
    if (mode == MODE_END) begin
      if (grp_open) begin
        v.group_closed = 1'b1;
        v.closed_sum   = grp_sum;
        v.sum_bad      = sum_out_of_bounds(grp_sum);
        grp_open = 1'b0;
        grp_sum  = '0;
        grp_bins.delete();
      end
    end else begin
      if (grp_open && (ev != grp_event || ar != grp_area)) begin
        v.group_closed = 1'b1;
        v.closed_sum   = grp_sum;
        v.sum_bad      = sum_out_of_bounds(grp_sum);
        if (ev < grp_event) v.order_fault = ORD_EVENT;
        else if (ev == grp_event && ar < grp_area) v.order_fault = ORD_AREA;
        grp_open = 1'b0;
      end
      if (!grp_open) begin
        grp_open  = 1'b1;
        grp_event = ev;
        grp_area  = ar;
        grp_sum   = sum_t'(p);
        grp_bins  = {bin};
      end else begin
        foreach (grp_bins[i]) if (grp_bins[i] == bin) found = 1'b1;
        if (found) v.duplicate_bin = 1'b1;
        else if (grp_bins.size() < BIN_LIST_DEPTH) grp_bins = {grp_bins, bin};
        else v.bin_overflow = 1'b1;
        acc = {1'b0, grp_sum} + p;
        grp_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      end
      if (bin > top_bin_seen) top_bin_seen = bin;
    end
    v.largest_bin = top_bin_seen;
    return v;
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic send_item(input logic mode, input event_t ev, input area_t ar,
                           input bin_t bin, input prob_t p);
    int       gap;
    verdict_t v_exp;
    gap = (tx_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.evt_id   <= ev;
    in_ch.area_id  <= ar;
    in_ch.bin_id   <= bin;
    in_ch.prob     <= p;
    do @(posedge clk); while (!in_ch.ready);
    v_exp = verdict_for_record(mode, ev, ar, bin, p);
    pending_verdicts = {pending_verdicts, v_exp};
    items_sent++;
    if (mode == MODE_RECORD) records_sent++;
  endtask

  // fields of an end-of-stream item are don't-care, so they carry noise
  task automatic send_end();
    send_item(MODE_END, event_t'($urandom()), area_t'($urandom()), bin_t'($urandom()),
              prob_t'($urandom()));
  endtask

  task automatic pause_input();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_bounds(input sum_t lo, input sum_t hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= REG_SUM_LOW;
    cfg_ch.data  <= lo;
    do @(posedge clk); while (!cfg_ch.ready);
    bound_lo = lo;
    cfg_ch.addr <= REG_SUM_HIGH;
    cfg_ch.data <= hi;
    do @(posedge clk); while (!cfg_ch.ready);
    bound_hi = hi;
    cfg_ch.valid <= 1'b0;
  endtask

  // long group: bins from a window of 80 fill the list, then overflow and repeats
  task automatic send_long_group(input int n, input bit heavy);
    bin_t  base;
    prob_t p;
    base = bin_t'($urandom_range(0, 65535 - 80));
    for (int i = 0; i < n; i++) begin
      p = heavy ? prob_t'($urandom_range(PROB_HEAVY_MIN, PROB_MAX))
                : prob_t'($urandom_range(0, PROB_MAX));
      send_item(MODE_RECORD, gen_event, gen_area, bin_t'(base + $urandom_range(0, 79)), p);
    end
  endtask

  task automatic send_group();
    int          r;
    int          n;
    bit          near_one;
    bit          few_bins;
    int unsigned remain;
    prob_t       p;
    bin_t        b;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_end();
      if ($urandom_range(0, 3) == 0) send_end();
      gen_event = event_t'($urandom());
      gen_area  = area_t'($urandom());
    end else if (r < 60) begin
      gen_area = gen_area + area_t'($urandom_range(1, 1000));
    end else if (r < 82) begin
      gen_event = gen_event + event_t'($urandom_range(1, 1 << 20));
      gen_area  = area_t'($urandom());
    end else if (r < 91) begin
      gen_event = event_t'($urandom_range(0, gen_event));
      gen_area  = area_t'($urandom());
    end else if (r < 96) begin
      gen_area = area_t'($urandom_range(0, gen_area));
    end else begin
      gen_event = event_t'($urandom());
      gen_area  = area_t'($urandom());
    end

    if ($urandom_range(0, 29) == 0) begin
      send_long_group($urandom_range(65, 150), $urandom_range(0, 1));
    end else begin
      n        = $urandom_range(1, 8);
      near_one = ($urandom_range(0, 9) < 7);
      few_bins = $urandom_range(0, 1);
      remain   = Q24_ONE + $urandom_range(0, 4000) - 2000;
      for (int i = 0; i < n; i++) begin
        if (near_one) begin
          p = (i == n - 1) ? prob_t'(remain) : prob_t'($urandom_range(0, remain));
          remain = remain - p;
        end else begin
          p = prob_t'($urandom_range(0, PROB_MAX));
        end
        b = few_bins ? bin_t'($urandom_range(0, 15)) : bin_t'($urandom_range(0, 65535));
        send_item(MODE_RECORD, gen_event, gen_area, b, p);
      end
    end
  endtask

  task automatic test_directed();
    send_end();                                            // nothing open yet
    send_item(MODE_RECORD, 31'd100, 32'd50, 16'd3, prob_t'(SUM_LOW_RESET));
    send_item(MODE_RECORD, 31'd100, 32'd50, 16'd3, '0);    // repeated bin
    send_item(MODE_RECORD, 31'd100, 32'd51, 16'd0, prob_t'(SUM_HIGH_RESET));
    send_item(MODE_RECORD, 31'd100, 32'd52, 16'd7, prob_t'(SUM_HIGH_RESET - 1));
    send_item(MODE_RECORD, 31'd100, 32'd52, 16'd8, '0);
    send_item(MODE_RECORD, 31'd100, 32'd20, 16'd1, prob_t'(SUM_LOW_RESET - 1));
    send_item(MODE_RECORD, 31'd40, '1, 16'd2, prob_t'(Q24_ONE));
    send_item(MODE_RECORD, 31'd40, '1, 16'd2, prob_t'(Q24_ONE));
    send_item(MODE_RECORD, '1, '0, 16'd5, prob_t'(PROB_MAX));
    send_item(MODE_RECORD, '1, '0, 16'd6, prob_t'(PROB_MAX));
    send_end();                                            // closes open group
    send_end();                                            // stream already closed
    send_item(MODE_RECORD, '0, '0, 16'd0, '0);             // no order check after end
    send_item(MODE_RECORD, '0, '0, 16'hFFFF, prob_t'(Q24_ONE));
    send_item(MODE_RECORD, '0, '0, 16'd0, '0);
    send_item(MODE_RECORD, '0, 32'd1, 16'd9, prob_t'(Q24_ONE));
    send_end();
    pause_input();
  endtask

  task automatic test_list_limits();
    gen_event = gen_event + 1;
    send_long_group(150, 1'b1);                            // saturates the sum
    gen_area = gen_area + 1;
    send_long_group(70, 1'b0);
    send_end();
    pause_input();
  endtask

  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    gen_event   = gen_event + 1;
    for (int i = 0; i < 16; i++)
      send_item(MODE_RECORD, gen_event, gen_area + area_t'(i / 4), bin_t'(i),
                prob_t'(Q24_ONE / 4));
    pause_input();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    sum_t lo;
    sum_t hi;
    int   goal;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      lo = SUM_LOW_RESET;
      hi = SUM_HIGH_RESET;
      case (ph)
        1: begin lo = '0;      hi = SUM_MAX; end
        2: begin lo = SUM_MAX; hi = '0;      end
        3: begin
          lo = Q24_ONE - $urandom_range(0, 3000);
          hi = Q24_ONE + $urandom_range(0, 3000);
        end
        4: begin lo = Q24_ONE + $urandom_range(0, 1000) - 500; hi = lo; end
        default: ;
      endcase
      if (ph != 0) begin
        pause_input();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_bounds(lo, hi);
      end
      tx_idle_en = (ph != 2 && ph != RANDOM_PHASES - 1);
      rx_idle_en = tx_idle_en;
      goal = records_sent + RANDOM_RECORDS / RANDOM_PHASES;
      while (records_sent < goal) send_group();
    end
  endtask

  // result sink: random stall bursts, plus one long hold on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        gap = $urandom_range(1, 19);
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t got;
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      got.group_closed  = out_ch.group_closed;
      got.sum_bad       = out_ch.sum_bad;
      got.order_fault   = out_ch.order_fault;
      got.duplicate_bin = out_ch.duplicate_bin;
      got.bin_overflow  = out_ch.bin_overflow;
      got.closed_sum    = out_ch.closed_sum;
      got.largest_bin   = out_ch.largest_bin;
      if (pending_verdicts.size() == 0) begin
        report_error($sformatf("result %0d transfer with nothing expected", results_seen));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.group_closed !== want.group_closed)
          report_error($sformatf("result %0d group_closed %0d, expected %0d",
                                 results_seen, got.group_closed, want.group_closed));
        if (got.sum_bad !== want.sum_bad)
          report_error($sformatf("result %0d sum_bad %0d, expected %0d",
                                 results_seen, got.sum_bad, want.sum_bad));
        if (got.order_fault !== want.order_fault)
          report_error($sformatf("result %0d order_fault %0d, expected %0d",
                                 results_seen, got.order_fault, want.order_fault));
        if (got.duplicate_bin !== want.duplicate_bin)
          report_error($sformatf("result %0d duplicate_bin %0d, expected %0d",
                                 results_seen, got.duplicate_bin, want.duplicate_bin));
        if (got.bin_overflow !== want.bin_overflow)
          report_error($sformatf("result %0d bin_overflow %0d, expected %0d",
                                 results_seen, got.bin_overflow, want.bin_overflow));
        if (got.closed_sum !== want.closed_sum)
          report_error($sformatf("result %0d closed_sum %0h, expected %0h",
                                 results_seen, got.closed_sum, want.closed_sum));
        if (got.largest_bin !== want.largest_bin)
          report_error($sformatf("result %0d largest_bin %0h, expected %0h",
                                 results_seen, got.largest_bin, want.largest_bin));
        closed_cnt += want.group_closed;
        bad_cnt    += want.sum_bad;
        order_cnt  += (want.order_fault != ORD_NONE);
        dup_cnt    += want.duplicate_bin;
        ovf_cnt    += want.bin_overflow;
        sat_cnt    += (want.group_closed && want.closed_sum == SUM_MAX);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_verdicts.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= MODE_RECORD;
    in_ch.evt_id   <= '0;
    in_ch.area_id  <= '0;
    in_ch.bin_id   <= '0;
    in_ch.prob     <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.addr    <= REG_SUM_LOW;
    cfg_ch.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_list_limits();
    test_backpressure();
    test_random_phases();

    pause_input();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items (%0d records) in %0d cycles over six bound settings; %0d results",
             items_sent, records_sent, cycle_count, results_seen);
    $display("groups closed %0d: out of bounds %0d, order faults %0d, saturated %0d",
             closed_cnt, bad_cnt, order_cnt, sat_cnt);
    $display("repeated bins %0d, list overflows %0d", dup_cnt, ovf_cnt);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/grsc_pkg.sv
sv/grsc_ifs.sv
sv/grsc_ram.sv
sv/grsc_ctrl.sv
sv/grsc_dp.sv
sv/grouped_record_stream_checker.sv
sim/tb_top.sv
